// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define PHL_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pad_hit_localizer_core port check failed");

// Property checked on every rising edge, reset included.
`define PHL_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pad_hit_localizer_core reset check failed");

`endif

// ===== hw/rtl/phl_pkg.sv =====
package phl_pkg;

    // Default geometry of the pad array and the capture.
    localparam int PAD_COUNT_DEF = 8;
    localparam int ROUNDS_DEF    = 16;

    // Field widths.
    localparam int SUM_W   = 14;
    localparam int BYTE_W  = 8;
    localparam int WIN_W   = 5;
    localparam int TICK_W  = 16;

    localparam logic [SUM_W-1:0] SUM_SAT = {SUM_W{1'b1}};

    // Configuration register indexes.
    localparam logic [1:0] REG_TRIGGER = 2'd0;
    localparam logic [1:0] REG_QUIET   = 2'd1;
    localparam logic [1:0] REG_DEBUG   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // Register reset values.
    localparam logic [BYTE_W-1:0] TRIGGER_RST = 8'd50;
    localparam logic [BYTE_W-1:0] QUIET_RST   = 8'd20;
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd20000;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_PAD   = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Colour codes.
    localparam logic [1:0] COL_NONE  = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_BLUE  = 2'd2;
    localparam logic [1:0] COL_GREEN = 2'd3;

    // Quiet rounds needed to end a cooldown.
    localparam logic [1:0] QUIET_MAX = 2'd3;

    // Control of the ring of sum cells, applied each cycle.
    typedef struct packed {
        logic              shift;
        logic              clear;
        logic [BYTE_W-1:0] add_val;
    } t_ring_ctl;

endpackage

// ===== hw/rtl/phl_cell.sv =====
module phl_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  phl_pkg::t_ring_ctl           i_ctl,
    input  logic                         i_tail,
    input  logic [phl_pkg::SUM_W-1:0]    i_prev,
    output logic [phl_pkg::SUM_W-1:0]    o_sum
);

    logic [phl_pkg::SUM_W-1:0] r_sum;
    logic [phl_pkg::SUM_W:0]   w_total;
    logic [phl_pkg::SUM_W-1:0] n_sum;

    // The tail cell adds the sample to the sum it takes from the head.
    always_comb begin
        w_total = {1'b0, i_prev} +
                  (i_tail ? (phl_pkg::SUM_W+1)'(i_ctl.add_val) : '0);
        if (w_total[phl_pkg::SUM_W]) begin
            n_sum = phl_pkg::SUM_SAT;
        end else begin
            n_sum = w_total[phl_pkg::SUM_W-1:0];
        end
    end

    // Sum register: clear wins over a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/phl_ring.sv =====
module phl_ring #(
    parameter int PAD_COUNT = phl_pkg::PAD_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  phl_pkg::t_ring_ctl           i_ctl,
    output logic [phl_pkg::SUM_W-1:0]    o_head
);

    logic [phl_pkg::SUM_W-1:0] w_sum [PAD_COUNT];

    // Each cell takes its neighbor's sum on a shift; the tail takes the head.
    for (genvar g = 0; g < PAD_COUNT; g++) begin : g_cell
        phl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_tail  ((g == PAD_COUNT - 1) ? 1'b1 : 1'b0),
            .i_prev  (w_sum[(g + 1) % PAD_COUNT]),
            .o_sum   (w_sum[g])
        );
    end

    assign o_head = w_sum[0];

endmodule

// ===== hw/rtl/pad_hit_localizer_core.sv =====
// Pad hit localizer.
// Input items (pad readouts with cmd 0, millisecond ticks with cmd 1) are
// transferred at a rising edge where start is high and busy is low. Readouts
// are assigned to pads in polling order; the pad_number field is not used.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
// Results appear for exactly one cycle with o_valid high, in the cycle after
// the edge that caused them; the receiver cannot stall them.
// The readout that completes the last capture round starts a walk of the ring
// of pad cells: a scan of every pad sum to find the winner, then one per-pad
// result per cycle, one for each pad. busy is high while the block scans and
// emits, and the first per-pad result shows once the scan is done.
// The walk length is set by the ring, which presents one pad sum per cycle.
// Synchronous reset puts the block in idle, clears the pad sums in the ring, the winner and
// the counters, and loads the register reset values.
module pad_hit_localizer_core #(
    parameter int PAD_COUNT = phl_pkg::PAD_COUNT_DEF,
    parameter int ROUNDS    = phl_pkg::ROUNDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [3:0]                    i_pad_number,
    input  logic [7:0]                    i_readout,
    input  logic                          i_timed_out,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_wdata,
    output logic                          o_valid,
    output logic [1:0]                    o_kind,
    output logic [3:0]                    o_result_pad,
    output logic [phl_pkg::SUM_W-1:0]     o_pad_sum,
    output logic [phl_pkg::WIN_W-1:0]     o_winner,
    output logic [1:0]                    o_colour,
    output logic                          o_last
);

    localparam int POS_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PAD_COUNT - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUNDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_SCAN,
        ST_EMIT,
        ST_COOL
    } t_state;

    // Configuration registers.
    logic [7:0]                  r_trigger;
    logic [7:0]                  r_quiet;
    logic                        r_debug;
    logic [15:0]                 r_timeout;

    // Control state.
    t_state                      r_state,    n_state;
    logic [POS_W-1:0]            r_pos,      n_pos;
    logic [POS_W-1:0]            r_walk,     n_walk;
    logic [CNT_W-1:0]            r_cnt,      n_cnt;
    logic [phl_pkg::SUM_W-1:0]   r_max,      n_max;
    logic [phl_pkg::WIN_W-1:0]   r_winner,   n_winner;
    logic                        r_red_done, n_red_done;
    logic                        r_dbg,      n_dbg;
    logic                        r_noisy,    n_noisy;
    logic [1:0]                  r_quiet_cnt, n_quiet_cnt;
    logic [15:0]                 r_elapsed,  n_elapsed;

    // Registered result.
    logic                        r_valid,    n_valid;
    logic [1:0]                  r_kind,     n_kind;
    logic [3:0]                  r_rpad,     n_rpad;
    logic [phl_pkg::SUM_W-1:0]   r_psum,     n_psum;
    logic [phl_pkg::WIN_W-1:0]   r_owin,     n_owin;
    logic [1:0]                  r_col,      n_col;
    logic                        r_last,     n_last;

    phl_pkg::t_ring_ctl          w_ctl;
    logic [phl_pkg::SUM_W-1:0]   w_head;
    logic                        w_accept;
    logic                        w_busy;
    logic [7:0]                  w_value;
    logic                        w_noisy_now;
    logic [1:0]                  w_quiet_next;
    logic [phl_pkg::SUM_W+1:0]   w_three_q;

    phl_ring #(
        .PAD_COUNT (PAD_COUNT)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    assign w_busy   = (r_state == ST_SCAN) || (r_state == ST_EMIT);
    assign w_accept = start && !w_busy;
    assign w_value  = i_timed_out ? 8'hFF : i_readout;
    assign w_three_q = ((phl_pkg::SUM_W+2)'(r_max) * 3) >> 2;

    // Cooldown round bookkeeping for the current readout.
    always_comb begin
        w_noisy_now = r_noisy || i_timed_out || (i_readout > r_quiet);
        if (w_noisy_now) begin
            w_quiet_next = '0;
        end else if (r_quiet_cnt < phl_pkg::QUIET_MAX) begin
            w_quiet_next = r_quiet_cnt + 2'd1;
        end else begin
            w_quiet_next = r_quiet_cnt;
        end
    end

    // Next-state logic for the sequencer and the result register.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_walk      = r_walk;
        n_cnt       = r_cnt;
        n_max       = r_max;
        n_winner    = r_winner;
        n_red_done  = r_red_done;
        n_dbg       = r_dbg;
        n_noisy     = r_noisy;
        n_quiet_cnt = r_quiet_cnt;
        n_elapsed   = r_elapsed;
        n_valid     = 1'b0;
        n_kind      = r_kind;
        n_rpad      = r_rpad;
        n_psum      = r_psum;
        n_owin      = r_owin;
        n_col       = r_col;
        n_last      = r_last;
        w_ctl       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_cmd == phl_pkg::CMD_SAMPLE) && !i_timed_out &&
                    (i_readout > r_trigger)) begin
                    n_state = ST_CAPTURE;
                    n_cnt   = '0;
                    n_pos   = '0;
                    n_valid = 1'b1;
                    n_kind  = phl_pkg::KIND_START;
                    n_rpad  = '0;
                    n_psum  = '0;
                    n_owin  = '0;
                    n_col   = phl_pkg::COL_NONE;
                    n_last  = 1'b0;
                end
            end

            ST_CAPTURE: begin
                if (w_accept && (i_cmd == phl_pkg::CMD_SAMPLE)) begin
                    w_ctl.shift   = 1'b1;
                    w_ctl.add_val = (w_value > r_trigger) ? w_value : '0;
                    if (r_pos == POS_LAST) begin
                        n_pos = '0;
                        if (r_cnt == CNT_LAST) begin
                            n_state = ST_SCAN;
                            n_walk  = '0;
                            n_max   = phl_pkg::SUM_W'(r_trigger);
                            n_dbg   = r_debug;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end

            // Winner search: one pad sum passes the head per cycle.
            ST_SCAN: begin
                w_ctl.shift = 1'b1;
                if (w_head > r_max) begin
                    n_max    = w_head;
                    n_winner = phl_pkg::WIN_W'(r_walk) + 1'b1;
                end
                if (r_walk == POS_LAST) begin
                    n_state    = ST_EMIT;
                    n_walk     = '0;
                    n_red_done = 1'b0;
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end

            // One per-pad result per cycle.
            ST_EMIT: begin
                w_ctl.shift = 1'b1;
                n_valid = 1'b1;
                n_kind  = phl_pkg::KIND_PAD;
                n_rpad  = 4'(r_walk);
                n_psum  = w_head;
                n_owin  = r_winner;
                n_last  = (r_walk == POS_LAST);
                n_col   = phl_pkg::COL_NONE;
                if (r_dbg) begin
                    if (!r_red_done && (w_head == r_max)) begin
                        n_col      = phl_pkg::COL_RED;
                        n_red_done = 1'b1;
                    end else if ((phl_pkg::SUM_W+2)'(w_head) > w_three_q) begin
                        n_col = phl_pkg::COL_BLUE;
                    end else if (w_head > (r_max >> 1)) begin
                        n_col = phl_pkg::COL_GREEN;
                    end
                end
                if (r_walk == POS_LAST) begin
                    n_walk = '0;
                    if (r_dbg) begin
                        n_state     = ST_COOL;
                        n_elapsed   = '0;
                        n_quiet_cnt = '0;
                        n_noisy     = 1'b0;
                    end else begin
                        w_ctl.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end

            ST_COOL: begin
                if (w_accept && (i_cmd == phl_pkg::CMD_TICK)) begin
                    if (r_elapsed != 16'hFFFF) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end else if (w_accept) begin
                    if (r_pos == POS_LAST) begin
                        n_pos   = '0;
                        n_noisy = 1'b0;
                        if ((r_elapsed > r_timeout) || (w_quiet_next > 2'd2)) begin
                            w_ctl.clear = 1'b1;
                            n_state     = ST_IDLE;
                            n_quiet_cnt = '0;
                            n_elapsed   = '0;
                            n_valid     = 1'b1;
                            n_kind      = phl_pkg::KIND_DONE;
                            n_rpad      = '0;
                            n_psum      = '0;
                            n_owin      = r_winner;
                            n_col       = phl_pkg::COL_NONE;
                            n_last      = 1'b1;
                        end else begin
                            n_quiet_cnt = w_quiet_next;
                        end
                    end else begin
                        n_noisy = w_noisy_now;
                        n_pos   = r_pos + 1'b1;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger   <= phl_pkg::TRIGGER_RST;
            r_quiet     <= phl_pkg::QUIET_RST;
            r_debug     <= 1'b0;
            r_timeout   <= phl_pkg::TIMEOUT_RST;
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_walk      <= '0;
            r_cnt       <= '0;
            r_winner    <= '0;
            r_red_done  <= 1'b0;
            r_dbg       <= 1'b0;
            r_noisy     <= 1'b0;
            r_quiet_cnt <= '0;
            r_elapsed   <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    phl_pkg::REG_TRIGGER: r_trigger <= i_cfg_wdata[7:0];
                    phl_pkg::REG_QUIET:   r_quiet   <= i_cfg_wdata[7:0];
                    phl_pkg::REG_DEBUG:   r_debug   <= i_cfg_wdata[0];
                    phl_pkg::REG_TIMEOUT: r_timeout <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_walk      <= n_walk;
            r_cnt       <= n_cnt;
            r_winner    <= n_winner;
            r_red_done  <= n_red_done;
            r_dbg       <= n_dbg;
            r_noisy     <= n_noisy;
            r_quiet_cnt <= n_quiet_cnt;
            r_elapsed   <= n_elapsed;
            r_valid     <= n_valid;
        end
        r_max  <= n_max;
        r_kind <= n_kind;
        r_rpad <= n_rpad;
        r_psum <= n_psum;
        r_owin <= n_owin;
        r_col  <= n_col;
        r_last <= n_last;
    end

    assign busy         = w_busy;
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_result_pad = r_rpad;
    assign o_pad_sum    = r_psum;
    assign o_winner     = r_owin;
    assign o_colour     = r_col;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/phl_checker.sv =====
`include "assert_macros.svh"

module phl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_cmd,
    input  logic [3:0]                    i_pad_number,
    input  logic [7:0]                    i_readout,
    input  logic                          i_timed_out,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic                          o_valid,
    input  logic [1:0]                    o_kind,
    input  logic [3:0]                    o_result_pad,
    input  logic [phl_pkg::SUM_W-1:0]     o_pad_sum,
    input  logic [phl_pkg::WIN_W-1:0]     o_winner,
    input  logic [1:0]                    o_colour,
    input  logic                          o_last
);

    // Reset leaves the block idle with no result transfer pending.
    `PHL_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !busy && !o_valid)

    // Only per-pad results carry a pad, a sum or a colour.
    `PHL_ASSERT(a_other_kinds_clean, o_valid && (o_kind != phl_pkg::KIND_PAD) |-> o_colour == phl_pkg::COL_NONE && o_result_pad == 4'd0 && o_pad_sum == '0)

    // A per-pad result that is not the final one is followed by the next pad.
    `PHL_ASSERT(a_pad_sequence, o_valid && (o_kind == phl_pkg::KIND_PAD) && !o_last |=> o_valid && (o_kind == phl_pkg::KIND_PAD) && (o_result_pad == 4'($past(o_result_pad) + 4'd1)))

    // The walk over pads keeps the input side closed until the final result.
    `PHL_ASSERT(a_busy_in_walk, o_valid && (o_kind == phl_pkg::KIND_PAD) && !o_last |-> busy)

    // A cooldown end always closes a run.
    `PHL_ASSERT(a_done_is_last, o_valid && (o_kind == phl_pkg::KIND_DONE) |-> o_last)

endmodule

bind pad_hit_localizer_core phl_checker u_phl_checker (.*);
